### src/psu_pkg.sv
// Shared constants, types and helpers for the particle swarm update block.
package psu_pkg;

	localparam int NUM_PARTICLES = 128;
	localparam int NUM_DIMS = 16;
	localparam int PI_W = 7;
	localparam int DI_W = 4;
	localparam int ADDR_W = PI_W + DI_W;

	localparam logic [2:0] OP_LOAD_ELEM = 3'd0;
	localparam logic [2:0] OP_LOAD_GLOBAL = 3'd1;
	localparam logic [2:0] OP_LOAD_PFIT = 3'd2;
	localparam logic [2:0] OP_LOAD_GFIT = 3'd3;
	localparam logic [2:0] OP_MOVE = 3'd4;
	localparam logic [2:0] OP_REPORT = 3'd5;

	localparam logic [2:0] REG_INERTIA = 3'd0;
	localparam logic [2:0] REG_COGNITIVE = 3'd1;
	localparam logic [2:0] REG_SOCIAL = 3'd2;
	localparam logic [2:0] REG_MAXIMIZE = 3'd3;
	localparam logic [2:0] REG_DIMS = 3'd4;

	// Last member sits in the lowest bits, so opcode lands at bit 0 of tdata
	typedef struct packed {
		logic [15:0] random_two;
		logic [15:0] random_one;
		logic signed [31:0] fitness_value;
		logic signed [31:0] velocity_value;
		logic signed [31:0] position_value;
		logic [DI_W-1:0] dimension_index;
		logic [PI_W-1:0] particle_index;
		logic [2:0] opcode;
	} item_t;

	typedef struct packed {
		logic signed [31:0] new_position;
		logic signed [31:0] new_velocity;
		logic personal_improved;
		logic global_improved;
		logic signed [31:0] global_best_fitness;
		logic saturated;
	} result_t;

	// Saturate a 36-bit signed value to 32 bits
	function automatic logic signed [31:0] sat36(input logic signed [35:0] v);
		logic signed [31:0] r;
		if (v > 36'sd2147483647) r = 32'sh7fffffff;
		else if (v < -36'sd2147483648) r = 32'sh80000000;
		else r = v[31:0];
		return r;
	endfunction

endpackage

### src/psu_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module psu_ram #(
	parameter int AW = 11,
	parameter int DW = 32
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [0:(1<<AW)-1];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

### src/psu_move.sv
// Velocity and position update datapath, five register stages.
module psu_move import psu_pkg::*; (
	input  logic               clk,
	input  logic               start,
	input  logic signed [31:0] x,
	input  logic signed [31:0] v,
	input  logic signed [31:0] p,
	input  logic signed [31:0] g,
	input  logic [15:0]        r1,
	input  logic [15:0]        r2,
	input  logic signed [31:0] w,
	input  logic signed [31:0] phi1,
	input  logic signed [31:0] phi2,
	output logic signed [31:0] xn,
	output logic signed [31:0] vn,
	output logic               sat
);
	// stage 1: coefficient products and differences
	logic signed [48:0] c1p_s1, c2p_s1;
	logic signed [32:0] dp_s1, dg_s1;
	logic signed [31:0] x_s1, v_s1, w_s1;
	always_ff @(posedge clk) begin
		if (start) begin
			c1p_s1 <= $signed({1'b0, r1}) * phi1;
			c2p_s1 <= $signed({1'b0, r2}) * phi2;
			dp_s1 <= 33'(p) - 33'(x);
			dg_s1 <= 33'(g) - 33'(x);
			x_s1 <= x;
			v_s1 <= v;
			w_s1 <= w;
		end
	end

	// stage 2: floor coefficients to Q16.16
	logic signed [32:0] c1_s2, c2_s2, dp_s2, dg_s2;
	logic signed [31:0] x_s2, v_s2, w_s2;
	always_ff @(posedge clk) begin
		c1_s2 <= c1p_s1[48:16];
		c2_s2 <= c2p_s1[48:16];
		dp_s2 <= dp_s1;
		dg_s2 <= dg_s1;
		x_s2 <= x_s1;
		v_s2 <= v_s1;
		w_s2 <= w_s1;
	end

	// stage 3: three term products
	logic signed [63:0] t0_s3;
	logic signed [65:0] t1_s3, t2_s3;
	logic signed [31:0] x_s3;
	always_ff @(posedge clk) begin
		t0_s3 <= w_s2 * v_s2;
		t1_s3 <= c1_s2 * dp_s2;
		t2_s3 <= c2_s2 * dg_s2;
		x_s3 <= x_s2;
	end

	// stage 4: floor each term and sum
	logic signed [51:0] sum_s4;
	logic signed [31:0] x_s4;
	always_ff @(posedge clk) begin
		sum_s4 <= 52'($signed(t0_s3[63:16])) + 52'($signed(t1_s3[65:16]))
			+ 52'($signed(t2_s3[65:16]));
		x_s4 <= x_s3;
	end

	// stage 5: saturate velocity, then position
	logic signed [31:0] vs;
	logic vclip;
	logic signed [32:0] xsum;
	always_comb begin
		vclip = (sum_s4 > 52'sd2147483647) || (sum_s4 < -52'sd2147483648);
		if (sum_s4 > 52'sd2147483647) vs = 32'sh7fffffff;
		else if (sum_s4 < -52'sd2147483648) vs = 32'sh80000000;
		else vs = sum_s4[31:0];
		xsum = 33'(x_s4) + 33'(vs);
	end
	always_ff @(posedge clk) begin
		vn <= vs;
		xn <= sat36(36'(xsum));
		sat <= vclip || (xsum > 33'sd2147483647) || (xsum < -33'sd2147483648);
	end
endmodule

### src/particle_swarm_update.sv
// Top level: sequencer around the particle state memories and move datapath.
// Loads go straight to the result; a move runs through the five-stage multiply datapath; a
// fitness report compares, then copies each improved row, personal then global.
// One item is taken at a time; the block returns to idle, ready for the next, as the result
// is registered, and the result register frees once tready takes it.
// Reset (arst_n low) clears control and sets config to defaults; memories undefined until written.
module particle_swarm_update import psu_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// opcode, particle_index, dimension_index, position_value, velocity_value,
	// fitness_value, random_one, random_two; zero fill to 144 bits
	input  logic [143:0] s_axis_tdata,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// new_position, new_velocity, personal_improved, global_improved,
	// global_best_fitness, saturated; zero fill to 104 bits
	output logic [103:0] m_axis_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_wdata
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_RD = 4'd1;
	localparam logic [3:0] ST_MOVE = 4'd2;
	localparam logic [3:0] ST_PCMP = 4'd3;
	localparam logic [3:0] ST_PCOPY = 4'd4;
	localparam logic [3:0] ST_GCMP = 4'd5;
	localparam logic [3:0] ST_GRD = 4'd6;
	localparam logic [3:0] ST_GCOPY = 4'd7;
	localparam logic [3:0] ST_OUT = 4'd8;

	// configuration
	logic signed [31:0] w_q, phi1_q, phi2_q;
	logic max_q;
	logic [4:0] dims_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 32'sd65536; phi1_q <= 32'sd65536; phi2_q <= 32'sd65536;
			max_q <= 1'b0; dims_q <= 5'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_INERTIA: w_q <= cfg_wdata;
				REG_COGNITIVE: phi1_q <= cfg_wdata;
				REG_SOCIAL: phi2_q <= cfg_wdata;
				REG_MAXIMIZE: max_q <= cfg_wdata[0];
				REG_DIMS: dims_q <= cfg_wdata[4:0];
				default: ;
			endcase
		end
	end

	item_t in_w;
	assign in_w = item_t'(s_axis_tdata[141:0]);

	logic [3:0] st_q;
	item_t it_q;
	logic [3:0] cnt_q;
	logic [2:0] mcnt_q;
	logic [4:0] ndim;
	logic pimp_q, gimp_q, vstart;
	logic signed [31:0] gfit_q;
	logic signed [31:0] pfit [0:NUM_PARTICLES-1];
	logic signed [31:0] gpos [0:NUM_DIMS-1];
	logic signed [31:0] pfit_rd_q;
	result_t res_q;
	logic ovalid_q;

	assign ndim = (dims_q > 5'(NUM_DIMS)) ? 5'(NUM_DIMS) : dims_q;

	// memory ports
	logic x_we, v_we, p_we;
	logic [ADDR_W-1:0] waddr, raddr;
	logic [31:0] x_wd, v_wd, p_wd, x_rd, v_rd, p_rd;
	logic signed [31:0] mv_x, mv_v, mv_sat_dummy;
	logic signed [31:0] mxn, mvn;
	logic msat;

	psu_ram #(.AW(ADDR_W), .DW(32)) u_x (.clk, .we(x_we), .waddr, .wdata(x_wd),
		.raddr, .rdata(x_rd));
	psu_ram #(.AW(ADDR_W), .DW(32)) u_v (.clk, .we(v_we), .waddr, .wdata(v_wd),
		.raddr, .rdata(v_rd));
	psu_ram #(.AW(ADDR_W), .DW(32)) u_p (.clk, .we(p_we), .waddr, .wdata(p_wd),
		.raddr, .rdata(p_rd));

	assign vstart = (st_q == ST_RD) && (it_q.opcode == OP_MOVE);
	assign mv_x = x_rd;
	assign mv_v = v_rd;
	assign mv_sat_dummy = gpos[it_q.dimension_index];

	psu_move u_move (.clk, .start(vstart), .x(mv_x), .v(mv_v), .p(p_rd),
		.g(mv_sat_dummy), .r1(it_q.random_one), .r2(it_q.random_two), .w(w_q),
		.phi1(phi1_q), .phi2(phi2_q), .xn(mxn), .vn(mvn), .sat(msat));

	logic better_p, better_g;
	assign better_p = max_q ? (it_q.fitness_value > pfit_rd_q)
	                        : (it_q.fitness_value < pfit_rd_q);
	assign better_g = max_q ? (pfit_rd_q > gfit_q) : (pfit_rd_q < gfit_q);

	// memory address and write control
	always_comb begin
		x_we = 1'b0; v_we = 1'b0; p_we = 1'b0;
		waddr = {it_q.particle_index, it_q.dimension_index};
		raddr = {it_q.particle_index, it_q.dimension_index};
		x_wd = it_q.position_value; v_wd = it_q.velocity_value;
		p_wd = it_q.position_value;
		unique case (st_q)
			// read the element of the incoming transaction as it is accepted
			ST_IDLE: raddr = {in_w.particle_index, in_w.dimension_index};
			ST_RD: begin
				if (it_q.opcode == OP_LOAD_ELEM) begin
					x_we = 1'b1; v_we = 1'b1; p_we = 1'b1;
				end
			end
			ST_MOVE: begin
				if (mcnt_q == 3'd6) begin
					x_we = 1'b1; v_we = 1'b1;
					x_wd = mxn; v_wd = mvn;
				end
			end
			ST_PCOPY: begin
				raddr = {it_q.particle_index, cnt_q};
				waddr = {it_q.particle_index, 4'(cnt_q - 4'd1)};
				p_wd = x_rd;
				p_we = mcnt_q[0];
			end
			ST_GRD, ST_GCOPY: raddr = {it_q.particle_index, cnt_q};
			default: ;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; ovalid_q <= 1'b0; cnt_q <= '0; mcnt_q <= '0;
			pimp_q <= 1'b0; gimp_q <= 1'b0;
		end else begin
			if (ovalid_q && m_axis_tready && st_q != ST_OUT) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: begin
					if (s_axis_tvalid && s_axis_tready) begin
						it_q <= in_w;
						st_q <= ST_RD;
					end
				end
				ST_RD: begin
					pimp_q <= 1'b0; gimp_q <= 1'b0;
					mcnt_q <= '0; cnt_q <= '0;
					res_q <= '0;
					pfit_rd_q <= pfit[it_q.particle_index];
					case (it_q.opcode)
						OP_LOAD_ELEM: st_q <= ST_OUT;
						OP_LOAD_GLOBAL: begin
							gpos[it_q.dimension_index] <= it_q.position_value;
							st_q <= ST_OUT;
						end
						OP_LOAD_PFIT: begin
							pfit[it_q.particle_index] <= it_q.fitness_value;
							st_q <= ST_OUT;
						end
						OP_LOAD_GFIT: begin
							gfit_q <= it_q.fitness_value;
							st_q <= ST_OUT;
						end
						OP_MOVE: st_q <= ST_MOVE;
						OP_REPORT: st_q <= ST_PCMP;
						default: st_q <= ST_OUT;
					endcase
				end
				ST_MOVE: begin
					mcnt_q <= mcnt_q + 3'd1;
					if (mcnt_q == 3'd6) begin
						res_q.new_position <= mxn;
						res_q.new_velocity <= mvn;
						res_q.saturated <= msat;
						st_q <= ST_OUT;
					end
				end
				ST_PCMP: begin
					if (better_p) begin
						pimp_q <= 1'b1;
						pfit[it_q.particle_index] <= it_q.fitness_value;
						pfit_rd_q <= it_q.fitness_value;
						st_q <= (ndim == 5'd0) ? ST_GCMP : ST_PCOPY;
					end else begin
						st_q <= ST_GCMP;
					end
				end
				ST_PCOPY: begin
					// alternate read then write of each element
					mcnt_q[0] <= ~mcnt_q[0];
					if (!mcnt_q[0]) cnt_q <= cnt_q + 4'd1;
					if (mcnt_q[0] && ({1'b0, 4'(cnt_q - 4'd1)} + 5'd1) == ndim) begin
						cnt_q <= '0; st_q <= ST_GCMP;
					end
				end
				ST_GCMP: begin
					mcnt_q <= '0;
					if (better_g) begin
						gimp_q <= 1'b1;
						gfit_q <= pfit_rd_q;
						st_q <= (ndim == 5'd0) ? ST_OUT : ST_GRD;
					end else begin
						st_q <= ST_OUT;
					end
				end
				ST_GRD: begin
					st_q <= ST_GCOPY;
				end
				ST_GCOPY: begin
					gpos[cnt_q] <= p_rd;
					if (5'(cnt_q) + 5'd1 == ndim) begin
						st_q <= ST_OUT;
					end else begin
						cnt_q <= cnt_q + 4'd1;
						st_q <= ST_GRD;
					end
				end
				ST_OUT: begin
					if (!ovalid_q || m_axis_tready) begin
						ovalid_q <= 1'b1;
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	result_t res_w;
	always_comb begin
		res_w = res_q;
		res_w.personal_improved = pimp_q;
		res_w.global_improved = gimp_q;
		res_w.global_best_fitness = gfit_q;
	end

	// output register
	result_t out_q;
	always_ff @(posedge clk) begin
		if (st_q == ST_OUT && (!ovalid_q || m_axis_tready)) out_q <= res_w;
	end

	assign s_axis_tready = (st_q == ST_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = {5'd0, out_q.saturated, out_q.global_best_fitness,
		out_q.global_improved, out_q.personal_improved, out_q.new_velocity,
		out_q.new_position};
endmodule

### sim/particle_swarm_update_test.sv
// Self-checking testbench for the particle swarm update block: driver, monitor and predictor.
`timescale 1ns / 1ps

module particle_swarm_update_test;
	import psu_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int LONG_HOLD = 120;

	typedef struct {
		item_t it;
		bit    drain;
	} pending_t;

	logic         clk;
	logic         arst_n;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [143:0] s_axis_tdata;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [103:0] m_axis_tdata;
	logic         cfg_we;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_wdata;

	particle_swarm_update dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	// Predicted state of the swarm
	logic [31:0] pos_mem [NUM_PARTICLES*NUM_DIMS];
	logic [31:0] vel_mem [NUM_PARTICLES*NUM_DIMS];
	logic [31:0] pbest_mem [NUM_PARTICLES*NUM_DIMS];
	logic [31:0] pbest_fit [NUM_PARTICLES];
	logic [31:0] gbest_pos [NUM_DIMS];
	logic [31:0] gbest_fit;
	logic [31:0] w_reg, phi1_reg, phi2_reg;
	logic        max_reg;
	logic [4:0]  dims_reg;

	// Which stores the generator has filled, so nothing unwritten is read
	bit elem_known [NUM_PARTICLES*NUM_DIMS];
	bit pfit_known [NUM_PARTICLES];
	bit glob_known [NUM_DIMS];
	bit gfit_known;
	int gen_dims;
	int pool [6];

	pending_t item_q [$];
	result_t  swarm_results_q [$];

	int mismatches = 0;
	int results_seen = 0;
	int moves_sent = 0, reports_sent = 0;
	int gap_cnt = 0, stall_cnt = 0, hold_cnt = 0;
	int idle_cycles = 0;
	bit burst = 0;
	bit hold_go = 0, hold_done = 0;

	// Clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch in %s: got %h, expected %h (result %0d)", what, got, want,
			results_seen);
		mismatches++;
	endtask

	function automatic logic [31:0] clip32(input longint a, inout bit clip);
		if (a > 64'sd2147483647) begin
			clip = 1;
			return 32'h7fffffff;
		end
		if (a < -64'sd2147483648) begin
			clip = 1;
			return 32'h80000000;
		end
		return a[31:0];
	endfunction

	function automatic bit is_better(input logic [31:0] a, input logic [31:0] b);
		return max_reg ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	// Apply one transaction to the predicted swarm and queue its result
	task automatic advance_swarm(input item_t it);
		result_t r;
		int e, row, d, j;
		longint x, v, p, g, c1, c2, r1, r2, sum, vn;
		bit clip;
		r = '0;
		clip = 0;
		e = it.particle_index * NUM_DIMS + it.dimension_index;
		row = it.particle_index * NUM_DIMS;
		d = (dims_reg > NUM_DIMS) ? NUM_DIMS : dims_reg;
		case (it.opcode)
			OP_LOAD_ELEM: begin
				pos_mem[e] = it.position_value;
				vel_mem[e] = it.velocity_value;
				pbest_mem[e] = it.position_value;
			end
			OP_LOAD_GLOBAL: gbest_pos[it.dimension_index] = it.position_value;
			OP_LOAD_PFIT: pbest_fit[it.particle_index] = it.fitness_value;
			OP_LOAD_GFIT: gbest_fit = it.fitness_value;
			OP_MOVE: begin
				x = $signed(pos_mem[e]);
				v = $signed(vel_mem[e]);
				p = $signed(pbest_mem[e]);
				g = $signed(gbest_pos[it.dimension_index]);
				r1 = it.random_one;
				r2 = it.random_two;
				c1 = (r1 * longint'($signed(phi1_reg))) >>> 16;
				c2 = (r2 * longint'($signed(phi2_reg))) >>> 16;
				sum = ((longint'($signed(w_reg)) * v) >>> 16) + ((c1 * (p - x)) >>> 16)
					+ ((c2 * (g - x)) >>> 16);
				vn = $signed(clip32(sum, clip));
				r.new_velocity = vn[31:0];
				r.new_position = clip32(x + vn, clip);
				vel_mem[e] = r.new_velocity;
				pos_mem[e] = r.new_position;
				r.saturated = clip;
			end
			OP_REPORT: begin
				if (is_better(it.fitness_value, pbest_fit[it.particle_index])) begin
					pbest_fit[it.particle_index] = it.fitness_value;
					for (j = 0; j < d; j++)
						pbest_mem[row + j] = pos_mem[row + j];
					r.personal_improved = 1;
				end
				if (is_better(pbest_fit[it.particle_index], gbest_fit)) begin
					gbest_fit = pbest_fit[it.particle_index];
					for (j = 0; j < d; j++)
						gbest_pos[j] = pbest_mem[row + j];
					r.global_improved = 1;
				end
			end
			default: ;
		endcase
		r.global_best_fitness = gbest_fit;
		swarm_results_q.push_back(r);
	endtask

	// Queue an item and note what it writes
	task automatic push_item(input logic [2:0] op, input int pi, input int di,
			input logic [31:0] pos, input logic [31:0] vel, input logic [31:0] fit,
			input logic [15:0] r1, input logic [15:0] r2, input bit drain);
		pending_t pt;
		pt.it.opcode = op;
		pt.it.particle_index = 7'(pi);
		pt.it.dimension_index = 4'(di);
		pt.it.position_value = pos;
		pt.it.velocity_value = vel;
		pt.it.fitness_value = fit;
		pt.it.random_one = r1;
		pt.it.random_two = r2;
		pt.drain = drain;
		case (op)
			OP_LOAD_ELEM: elem_known[pi*NUM_DIMS + di] = 1;
			OP_LOAD_GLOBAL: glob_known[di] = 1;
			OP_LOAD_PFIT: pfit_known[pi] = 1;
			OP_LOAD_GFIT: gfit_known = 1;
			OP_MOVE: moves_sent++;
			OP_REPORT: reports_sent++;
			default: ;
		endcase
		item_q.push_back(pt);
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1: return $urandom;
			2: return 32'h7fffffff;
			3: return 32'h80000000;
			default: return $urandom_range(0, 32'h00ffffff) - 32'h00800000;
		endcase
	endfunction

	// One random item; well-formed ones are repaired into the load they depend on
	task automatic push_random(input bit drain);
		int sel, pi, di, d, j, e;
		logic [2:0] op;
		sel = $urandom_range(0, 99);
		pi = pool[$urandom_range(0, 5)];
		di = $urandom_range(0, NUM_DIMS - 1);
		e = pi * NUM_DIMS + di;
		d = (gen_dims > NUM_DIMS) ? NUM_DIMS : gen_dims;
		if (sel < 6) begin
			op = 3'($urandom_range(6, 7));
			pi = $urandom_range(0, NUM_PARTICLES - 1);
		end else if (sel < 45) begin
			op = OP_MOVE;
			if (!elem_known[e])
				op = OP_LOAD_ELEM;
			else if (!glob_known[di])
				op = OP_LOAD_GLOBAL;
		end else if (sel < 75) begin
			op = OP_REPORT;
			for (j = d - 1; j >= 0; j--) begin
				if (!elem_known[pi*NUM_DIMS + j]) begin
					op = OP_LOAD_ELEM;
					di = j;
				end
			end
			if (!pfit_known[pi])
				op = OP_LOAD_PFIT;
			if (!gfit_known)
				op = OP_LOAD_GFIT;
		end else if (sel < 85) begin
			op = OP_LOAD_ELEM;
			if ($urandom_range(0, 3) == 0)
				pi = $urandom_range(0, NUM_PARTICLES - 1);
		end else if (sel < 90) begin
			op = OP_LOAD_GLOBAL;
		end else if (sel < 95) begin
			op = OP_LOAD_PFIT;
		end else begin
			op = OP_LOAD_GFIT;
		end
		push_item(op, pi, di, pick_value(), pick_value(), pick_value(),
			16'($urandom), 16'($urandom), drain);
	endtask

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			REG_INERTIA: w_reg = val;
			REG_COGNITIVE: phi1_reg = val;
			REG_SOCIAL: phi2_reg = val;
			REG_MAXIMIZE: max_reg = val[0];
			REG_DIMS: begin
				dims_reg = val[4:0];
				gen_dims = val[4:0];
			end
			default: ;
		endcase
	endtask

	task automatic set_swarm_config(input logic [31:0] w, input logic [31:0] phi1,
			input logic [31:0] phi2, input logic mx, input logic [4:0] dims);
		write_reg(REG_INERTIA, w);
		write_reg(REG_COGNITIVE, phi1);
		write_reg(REG_SOCIAL, phi2);
		write_reg(REG_MAXIMIZE, {31'b0, mx});
		write_reg(REG_DIMS, {27'b0, dims});
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// Wait for the block to drain before touching configuration
	task automatic wait_idle();
		while (item_q.size() != 0 || swarm_results_q.size() != 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic run_random_phase(input int count);
		int k;
		for (k = 0; k < 6; k++)
			pool[k] = $urandom_range(0, NUM_PARTICLES - 1);
		pool[0] = 0;
		pool[1] = NUM_PARTICLES - 1;
		for (k = 0; k < count; k++)
			push_random(k % 90 == 89);
	endtask

	// Driver: offer queued transactions with random gaps
	always @(posedge clk or negedge arst_n) begin
		pending_t pt;
		bit offer;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			gap_cnt = 0;
		end else begin
			offer = s_axis_tvalid;
			if (s_axis_tvalid && s_axis_tready) begin
				advance_swarm(s_axis_tdata[141:0]);
				offer = 0;
			end
			if (!offer) begin
				if (gap_cnt > 0) begin
					gap_cnt--;
				end else if (item_q.size() != 0 &&
						(!item_q[0].drain || swarm_results_q.size() == 0)) begin
					pt = item_q.pop_front();
					s_axis_tdata <= {2'b0, pt.it.random_two, pt.it.random_one,
						pt.it.fitness_value, pt.it.velocity_value, pt.it.position_value,
						pt.it.dimension_index, pt.it.particle_index, pt.it.opcode};
					offer = 1;
					if ($urandom_range(0, 40) == 0)
						burst = !burst;
					gap_cnt = burst ? 0 : $urandom_range(0, 4);
				end
			end
			s_axis_tvalid <= offer;
		end
	end

	// Monitor: accept results with random stalls and check them
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		logic [31:0] got_pos, got_vel, got_gbf;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_pos = m_axis_tdata[31:0];
				got_vel = m_axis_tdata[63:32];
				got_gbf = m_axis_tdata[97:66];
				if (swarm_results_q.size() == 0) begin
					report_mismatch("unexpected result", got_pos, '0);
				end else begin
					want = swarm_results_q.pop_front();
					if (got_pos !== want.new_position)
						report_mismatch("new_position", got_pos, want.new_position);
					if (got_vel !== want.new_velocity)
						report_mismatch("new_velocity", got_vel, want.new_velocity);
					if (m_axis_tdata[64] !== want.personal_improved)
						report_mismatch("personal_improved", m_axis_tdata[64],
							want.personal_improved);
					if (m_axis_tdata[65] !== want.global_improved)
						report_mismatch("global_improved", m_axis_tdata[65],
							want.global_improved);
					if (got_gbf !== want.global_best_fitness)
						report_mismatch("global_best_fitness", got_gbf,
							want.global_best_fitness);
					if (m_axis_tdata[98] !== want.saturated)
						report_mismatch("saturated", m_axis_tdata[98], want.saturated);
				end
				results_seen++;
				stall_cnt = burst ? 0 : $urandom_range(0, 4);
			end
			if (hold_go && !hold_done) begin
				hold_done = 1;
				hold_cnt = LONG_HOLD;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				m_axis_tready <= 1'b0;
			end else if (stall_cnt > 0) begin
				stall_cnt--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if nothing moves while work is outstanding
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(item_q.size() == 0 && swarm_results_q.size() == 0 && !s_axis_tvalid))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", WATCHDOG_LIMIT);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Stimulus and phases
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		w_reg = 32'h00010000;
		phi1_reg = 32'h00010000;
		phi2_reg = 32'h00010000;
		max_reg = 1'b0;
		dims_reg = 5'd1;
		gen_dims = 1;
		gbest_fit = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		set_swarm_config(32'h00010000, 32'h00010000, 32'h00010000, 1'b0, 5'd1);

		// Directed: extremes, every opcode, saturation, better and worse reports
		push_item(OP_LOAD_GFIT, 0, 0, 0, 0, 32'h7fffffff, 0, 0, 0);
		push_item(OP_LOAD_GLOBAL, 0, 0, 32'h80000000, 0, 0, 0, 0, 0);
		push_item(OP_LOAD_GLOBAL, 0, 15, 32'h7fffffff, 0, 0, 0, 0, 0);
		push_item(OP_LOAD_ELEM, 0, 0, 32'h7fffffff, 32'h7fffffff, 0, 0, 0, 0);
		push_item(OP_LOAD_ELEM, 127, 15, 32'h80000000, 32'h80000000, 0, 0, 0, 0);
		push_item(OP_LOAD_ELEM, 127, 0, 32'h00030000, 32'hfffe0000, 0, 0, 0, 0);
		push_item(OP_LOAD_PFIT, 0, 0, 0, 0, 32'h00050000, 0, 0, 0);
		push_item(OP_LOAD_PFIT, 127, 15, 0, 0, 32'h80000000, 0, 0, 0);
		push_item(OP_MOVE, 0, 0, 0, 0, 0, 16'hffff, 16'hffff, 0);
		push_item(OP_MOVE, 127, 15, 0, 0, 0, 16'hffff, 16'hffff, 0);
		push_item(OP_MOVE, 0, 0, 0, 0, 0, 0, 0, 0);
		push_item(OP_REPORT, 0, 0, 0, 0, 32'h00010000, 0, 0, 0);
		push_item(OP_REPORT, 0, 0, 0, 0, 32'h00090000, 0, 0, 0);
		push_item(OP_REPORT, 127, 15, 0, 0, 32'h7fffffff, 0, 0, 0);
		push_item(3'd6, 5, 3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 16'hffff,
			16'hffff, 0);
		push_item(3'd7, 127, 15, 0, 0, 0, 0, 0, 0);
		push_item(OP_LOAD_ELEM, 0, 0, 0, 0, 0, 0, 0, 0);
		push_item(OP_MOVE, 0, 0, 0, 0, 0, 16'h8000, 16'h0001, 0);
		run_random_phase(150);
		wait_idle();

		// Half inertia, maximise, full rows; long receiver hold-off
		set_swarm_config(32'h00008000, 32'h00018000, 32'h00020000, 1'b1, 5'd16);
		hold_go <= 1'b1;
		run_random_phase(230);
		wait_idle();

		// Extreme gains, dimension count beyond the row
		set_swarm_config(32'h7fffffff, 32'h80000000, 32'h7fffffff, 1'b0, 5'd31);
		run_random_phase(200);
		wait_idle();

		// Negative inertia, no rows copied
		set_swarm_config(32'hffff0000, $urandom_range(0, 32'h0003ffff),
			32'h80000000, 1'b1, 5'd0);
		run_random_phase(200);
		wait_idle();

		set_swarm_config($urandom, $urandom, $urandom, 1'($urandom_range(0, 1)),
			5'($urandom_range(0, 31)));
		run_random_phase(250);
		wait_idle();
		repeat (20) @(posedge clk);

		$display("covered %0d results: %0d moves and %0d fitness reports over five",
			results_seen, moves_sent, reports_sent);
		$display("gain settings, both best modes and row lengths 0, 1, 16 and above");
		if (mismatches == 0 && swarm_results_q.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

### files.f
src/psu_pkg.sv
src/psu_ram.sv
src/psu_move.sv
src/particle_swarm_update.sv
sim/particle_swarm_update_test.sv
